// ===== hw/rtl/olst_pkg.sv =====
`default_nettype none
package olst_pkg;

  localparam int CAPACITY   = 64;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  // Field widths fixed by the command/result format
  localparam int CMD_W    = 3;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // compare width: holds a position, a count and count+1 without wrap
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_GET    = 3'd2,
    CMD_LOCATE = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // Broadcast from the controller to every cell for one command
  typedef struct packed {
    logic                  ins;      // insert accepted
    logic                  del;      // delete accepted
    logic                  rd;       // get accepted
    logic                  loc;      // locate
    logic [CMP_W-1:0]      pos_idx;  // 0-based target slot
    logic [CNT_W-1:0]      used;     // entries before the command
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/olst_cell.sv =====
`default_nettype none
// One list slot: holds an entry, shifts to/from neighbors, flags get/locate hits.
module olst_cell (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [olst_pkg::IDX_W-1:0]      cell_index,
  input  wire olst_pkg::cell_ctrl_t            ctrl,
  input  wire logic [olst_pkg::KEY_BITS-1:0]   left_key,
  input  wire logic [olst_pkg::VALUE_BITS-1:0] left_value,
  input  wire logic [olst_pkg::KEY_BITS-1:0]   right_key,
  input  wire logic [olst_pkg::VALUE_BITS-1:0] right_value,
  output logic      [olst_pkg::KEY_BITS-1:0]   slot_key,
  output logic      [olst_pkg::VALUE_BITS-1:0] slot_value,
  output logic                                 sel,
  output logic                                 match
);

  logic [olst_pkg::CMP_W-1:0] idx_ext;
  logic                       at_pos;
  logic                       past_pos;
  logic                       live;

  assign idx_ext  = olst_pkg::CMP_W'(cell_index);
  assign at_pos   = (idx_ext == ctrl.pos_idx);
  assign past_pos = (idx_ext > ctrl.pos_idx);
  assign live     = (idx_ext < olst_pkg::CMP_W'(ctrl.used));

  // entry storage, no reset: slots beyond the list length are never used
  always_ff @(posedge clk) begin
    if (ctrl.ins && at_pos) begin
      slot_key   <= ctrl.key;
      slot_value <= ctrl.value;
    end else if (ctrl.ins && past_pos) begin
      slot_key   <= left_key;
      slot_value <= left_value;
    end else if (ctrl.del && (at_pos || past_pos)) begin
      slot_key   <= right_key;
      slot_value <= right_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel   <= 1'b0;
      match <= 1'b0;
    end else begin
      sel   <= ctrl.rd && at_pos;
      match <= ctrl.loc && live && (slot_key == ctrl.key);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/olst_collect.sv =====
`default_nettype none
// Gathers the registered cell flags: one-hot read mux and first-match encoder.
module olst_collect (
  input  wire logic [olst_pkg::KEY_BITS-1:0]   slot_keys   [olst_pkg::CAPACITY],
  input  wire logic [olst_pkg::VALUE_BITS-1:0] slot_values [olst_pkg::CAPACITY],
  input  wire logic [olst_pkg::CAPACITY-1:0]   sel,
  input  wire logic [olst_pkg::CAPACITY-1:0]   match,
  output logic      [olst_pkg::KEY_BITS-1:0]   read_key,
  output logic      [olst_pkg::VALUE_BITS-1:0] read_value,
  output logic      [olst_pkg::CNT_W-1:0]      found_slot
);

  always_comb begin
    read_key   = '0;
    read_value = '0;
    for (int i = 0; i < olst_pkg::CAPACITY; i++) begin
      read_key   = read_key   | ({olst_pkg::KEY_BITS{sel[i]}}   & slot_keys[i]);
      read_value = read_value | ({olst_pkg::VALUE_BITS{sel[i]}} & slot_values[i]);
    end
  end

  // lowest matching slot wins; 1-based, 0 when none
  always_comb begin
    found_slot = '0;
    for (int i = olst_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        found_slot = olst_pkg::CNT_W'(i + 1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ordered_list_engine.sv =====
`default_nettype none
// Ordered key/value list engine, up to CAPACITY entries at 1-based positions.
// A command beat is taken when start is high and busy is low; busy then stays
// high for one cycle, so the next command may be taken during the gather step
// of the previous one. Each command gives exactly one result beat, shown for a
// single cycle with done high: first the slot cells update (insert/delete shift
// the cells from the target position on by one place in parallel, get and
// locate set per-cell hit flags), then the hit flags are gathered into the read
// data and the first-match position. The receiver cannot stall; it must
// capture the result in the cycle done is high. No clearing pass after reset.
module ordered_list_engine (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [olst_pkg::CMD_W-1:0]           cmd,
  input  wire logic [olst_pkg::POS_W-1:0]           position,
  input  wire logic [olst_pkg::KEY_BITS-1:0]        entry_key,
  input  wire logic [olst_pkg::VALUE_BITS-1:0]      entry_value,
  output logic                                      done,
  output logic      [olst_pkg::STATUS_W-1:0]        status,
  output logic      [olst_pkg::POS_W-1:0]           found_position,
  output logic      [olst_pkg::KEY_BITS-1:0]        read_key,
  output logic      [olst_pkg::VALUE_BITS-1:0]      read_value,
  output logic      [olst_pkg::POS_W-1:0]           list_count,
  output logic                                      is_empty
);

  // ---- stage 1: latched command ----
  logic                              cmd_valid;
  olst_pkg::cmd_t                    cmd_q;
  logic [olst_pkg::POS_W-1:0]        pos_q;
  logic [olst_pkg::KEY_BITS-1:0]     key_q;
  logic [olst_pkg::VALUE_BITS-1:0]   value_q;

  // ---- list length ----
  logic [olst_pkg::CNT_W-1:0]        used;
  logic [olst_pkg::CNT_W-1:0]        used_next;

  // ---- stage 2: command result pending collection ----
  logic                              res_valid;
  olst_pkg::status_t                 res_status;
  olst_pkg::status_t                 status_next;

  olst_pkg::cell_ctrl_t              ctrl;

  logic [olst_pkg::CMP_W-1:0]        pos_ext;
  logic [olst_pkg::CMP_W-1:0]        used_ext;
  logic                              pos_zero;
  logic                              full;

  logic [olst_pkg::KEY_BITS-1:0]     slot_keys   [olst_pkg::CAPACITY];
  logic [olst_pkg::VALUE_BITS-1:0]   slot_values [olst_pkg::CAPACITY];
  logic [olst_pkg::CAPACITY-1:0]     sel;
  logic [olst_pkg::CAPACITY-1:0]     match;

  logic [olst_pkg::KEY_BITS-1:0]     col_key;
  logic [olst_pkg::VALUE_BITS-1:0]   col_value;
  logic [olst_pkg::CNT_W-1:0]        col_found;

  assign busy = cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q   <= olst_pkg::cmd_t'(cmd);
      pos_q   <= position;
      key_q   <= entry_key;
      value_q <= entry_value;
    end
  end

  // ---- command decode against the current length ----
  assign pos_ext  = olst_pkg::CMP_W'(pos_q);
  assign used_ext = olst_pkg::CMP_W'(used);
  assign pos_zero = (pos_q == '0);
  assign full     = (used == olst_pkg::CNT_W'(olst_pkg::CAPACITY));

  always_comb begin
    ctrl         = '0;
    ctrl.pos_idx = pos_ext - olst_pkg::CMP_W'(1);
    ctrl.used    = used;
    ctrl.key     = key_q;
    ctrl.value   = value_q;
    status_next  = olst_pkg::STATUS_OK;
    used_next    = used;
    if (cmd_valid) begin
      unique case (cmd_q)
        olst_pkg::CMD_INSERT: begin
          if (pos_zero || (pos_ext > used_ext + olst_pkg::CMP_W'(1))) begin
            status_next = olst_pkg::STATUS_RANGE;
          end else if (full) begin
            status_next = olst_pkg::STATUS_FULL;
          end else begin
            ctrl.ins  = 1'b1;
            used_next = used + olst_pkg::CNT_W'(1);
          end
        end
        olst_pkg::CMD_DELETE: begin
          if (pos_zero || (pos_ext > used_ext)) begin
            status_next = olst_pkg::STATUS_RANGE;
          end else begin
            ctrl.del  = 1'b1;
            used_next = used - olst_pkg::CNT_W'(1);
          end
        end
        olst_pkg::CMD_GET: begin
          if (pos_zero || (pos_ext > used_ext)) begin
            status_next = olst_pkg::STATUS_RANGE;
          end else begin
            ctrl.rd = 1'b1;
          end
        end
        olst_pkg::CMD_LOCATE: begin
          ctrl.loc = 1'b1;
        end
        olst_pkg::CMD_CLEAR: begin
          used_next = '0;
        end
        default: begin
          // unused codes: no change, status ok
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      res_valid <= 1'b0;
    end else begin
      used      <= used_next;
      res_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid) begin
      res_status <= status_next;
    end
  end

  // ---- row of slot cells; cell 0 holds position 1 ----
  for (genvar i = 0; i < olst_pkg::CAPACITY; i++) begin : g_cell
    logic [olst_pkg::KEY_BITS-1:0]   lk;
    logic [olst_pkg::VALUE_BITS-1:0] lv;
    logic [olst_pkg::KEY_BITS-1:0]   rk;
    logic [olst_pkg::VALUE_BITS-1:0] rv;

    if (i == 0) begin : g_first
      assign lk = '0;
      assign lv = '0;
    end else begin : g_mid_l
      assign lk = slot_keys[i-1];
      assign lv = slot_values[i-1];
    end

    // last cell pulls nothing meaningful on delete: it falls outside the list
    if (i == olst_pkg::CAPACITY - 1) begin : g_last
      assign rk = '0;
      assign rv = '0;
    end else begin : g_mid_r
      assign rk = slot_keys[i+1];
      assign rv = slot_values[i+1];
    end

    olst_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cell_index  (olst_pkg::IDX_W'(i)),
      .ctrl        (ctrl),
      .left_key    (lk),
      .left_value  (lv),
      .right_key   (rk),
      .right_value (rv),
      .slot_key    (slot_keys[i]),
      .slot_value  (slot_values[i]),
      .sel         (sel[i]),
      .match       (match[i])
    );
  end

  olst_collect u_collect (
    .slot_keys   (slot_keys),
    .slot_values (slot_values),
    .sel         (sel),
    .match       (match),
    .read_key    (col_key),
    .read_value  (col_value),
    .found_slot  (col_found)
  );

  // ---- result register: one beat per command ----
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      status         <= res_status;
      found_position <= olst_pkg::POS_W'(col_found);
      read_key       <= col_key;
      read_value     <= col_value;
      list_count     <= olst_pkg::POS_W'(used);
      is_empty       <= (used == '0);
    end
  end

endmodule
`default_nettype wire
